// ===== hw/rtl/rra_pkg.sv =====
// shared types, codes and helpers of the range register allocator
package rra_pkg;

	// default number of range entries
	localparam int NUM_RANGES_DEF = 8;

	// field widths
	localparam int CMD_W    = 3;
	localparam int ADDR_W   = 52;
	localparam int IDX_W    = 3;
	localparam int STAT_W   = 4;
	localparam int WORD_W   = 64;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W    = 6;

	// commands
	localparam logic [CMD_W-1:0] CMD_SETUP   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ENABLE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DISABLE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_COPY    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK          = 4'd0;
	localparam logic [STAT_W-1:0] STAT_BELOW_1M    = 4'd1;
	localparam logic [STAT_W-1:0] STAT_ABOVE_LIMIT = 4'd2;
	localparam logic [STAT_W-1:0] STAT_UNDER_4K    = 4'd3;
	localparam logic [STAT_W-1:0] STAT_NOT_POW2    = 4'd4;
	localparam logic [STAT_W-1:0] STAT_MISALIGNED  = 4'd5;
	localparam logic [STAT_W-1:0] STAT_NO_RANGES   = 4'd6;
	localparam logic [STAT_W-1:0] STAT_NO_WC       = 4'd7;
	localparam logic [STAT_W-1:0] STAT_OVERLAP     = 4'd8;
	localparam logic [STAT_W-1:0] STAT_FULL        = 4'd9;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_RANGES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PHYS_BITS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGES_SUPP   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WC_SUPP       = 2'd3;

	// configuration reset values
	localparam logic [3:0] ACTIVE_RANGES_RST = 4'd8;
	localparam logic [5:0] PHYS_BITS_RST     = 6'd36;

	// entry word fields and region limits
	localparam int VALID_POS          = 11;
	localparam logic [WORD_W-1:0] VALID_BIT  = 64'h800;
	localparam logic [WORD_W-1:0] TYPE_WC    = 64'h01;
	localparam logic [WORD_W-1:0] TYPE_FIELD = 64'hFF;
	localparam int MIN_BASE_SHIFT   = 20;
	localparam int BASE_LIMIT_SHIFT = 36;
	localparam int MIN_SIZE_SHIFT   = 12;
	localparam int PHYS_BITS_MIN    = 36;
	localparam int PHYS_BITS_MAX    = 52;

	// input beat
	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [ADDR_W-1:0] region_base;
		logic [ADDR_W-1:0] region_size;
		logic [IDX_W-1:0]  entry_index;
		logic [IDX_W-1:0]  source_index;
	} rra_in_t;

	// result beat
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [IDX_W-1:0]  chosen_index;
		logic [WORD_W-1:0] entry_base_word;
		logic [WORD_W-1:0] entry_mask_word;
	} rra_out_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_WRITE,
		S_PUSH
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic check;
		logic exec;
		logic scan;
		logic write;
		logic push;
	} rra_ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic is_setup;
		logic check_fail;
		logic scan_empty;
		logic scan_hit;
		logic scan_last;
		logic free_avail;
		logic out_free;
	} rra_sts_t;

	// address window: bits 12..31 plus 32..width-1, width clamped to 36..52
	function automatic logic [WORD_W-1:0] addr_window(input logic [5:0] phys_bits);
		logic [WORD_W-1:0] win;
		int lim;
		win = '0;
		if (int'(phys_bits) < PHYS_BITS_MIN) begin
			lim = PHYS_BITS_MIN;
		end else if (int'(phys_bits) > PHYS_BITS_MAX) begin
			lim = PHYS_BITS_MAX;
		end else begin
			lim = int'(phys_bits);
		end
		win[31:12] = '1;
		for (int j = 32; j < PHYS_BITS_MAX; j++) begin
			win[j] = (j < lim);
		end
		return win;
	endfunction

endpackage

// ===== hw/rtl/rra_ctrl.sv =====
// controller state machine of the range register allocator
module rra_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  rra_pkg::rra_sts_t sts,
	output rra_pkg::rra_ctl_t ctl
);

	rra_pkg::state_t state_q;
	rra_pkg::state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rra_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rra_pkg::S_IDLE: begin
				if (in_valid) begin
					state_nxt = rra_pkg::S_CHECK;
				end
			end
			rra_pkg::S_CHECK: begin
				if (!sts.is_setup || sts.check_fail || sts.scan_empty) begin
					state_nxt = rra_pkg::S_PUSH;
				end else begin
					state_nxt = rra_pkg::S_SCAN;
				end
			end
			rra_pkg::S_SCAN: begin
				if (sts.scan_hit) begin
					state_nxt = rra_pkg::S_PUSH;
				end else if (sts.scan_last) begin
					state_nxt = sts.free_avail ? rra_pkg::S_WRITE : rra_pkg::S_PUSH;
				end
			end
			rra_pkg::S_WRITE: begin
				state_nxt = rra_pkg::S_PUSH;
			end
			rra_pkg::S_PUSH: begin
				if (sts.out_free) begin
					state_nxt = rra_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = rra_pkg::S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		ctl       = '0;
		in_stall  = 1'b1;
		case (state_q)
			rra_pkg::S_IDLE: begin
				in_stall = 1'b0;
				ctl.load = in_valid;
			end
			rra_pkg::S_CHECK: begin
				ctl.check = sts.is_setup;
				ctl.exec  = !sts.is_setup;
			end
			rra_pkg::S_SCAN: begin
				ctl.scan = 1'b1;
			end
			rra_pkg::S_WRITE: begin
				ctl.write = 1'b1;
			end
			rra_pkg::S_PUSH: begin
				ctl.push = 1'b1;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// ===== hw/rtl/rra_datapath.sv =====
// datapath of the range register allocator: entry table, checks, scan and result
module rra_datapath #(
	parameter int NUM_RANGES = rra_pkg::NUM_RANGES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rra_pkg::rra_in_t                  in_data,
	input  rra_pkg::rra_ctl_t                 ctl,
	output rra_pkg::rra_sts_t                 sts,
	input  logic                              cfg_write,
	input  logic [rra_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rra_pkg::CFG_W-1:0]         cfg_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output rra_pkg::rra_out_t                 out_data
);

	localparam int IW = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
	localparam int CW = $clog2(NUM_RANGES + 1) + 1;
	localparam int AW = rra_pkg::ADDR_W;
	localparam int WW = rra_pkg::WORD_W;

	// entry table
	logic [WW-1:0] rbase_q [NUM_RANGES];
	logic [WW-1:0] rmask_q [NUM_RANGES];

	// configuration registers
	logic [3:0] active_q;
	logic [5:0] phys_q;
	logic       ranges_q;
	logic       wc_q;

	// captured input beat
	logic [rra_pkg::CMD_W-1:0] cmd_q;
	logic [AW-1:0]             base_q;
	logic [AW-1:0]             size_q;
	logic [rra_pkg::IDX_W-1:0] dst_q;
	logic [rra_pkg::IDX_W-1:0] src_q;

	// set-up working registers
	logic [AW-1:0] sizem1_q;
	logic [AW:0]   end_q;
	logic [IW-1:0] scan_idx_q;
	logic [IW-1:0] free_q;
	logic          free_found_q;

	// staged result and output register
	rra_pkg::rra_out_t res_q;
	rra_pkg::rra_out_t out_q;
	logic              out_valid_q;

	// combinational signals
	logic [WW-1:0]              win;
	logic [CW-1:0]              scan_len;
	logic [IW-1:0]              rd_addr;
	logic [WW-1:0]              rd_base;
	logic [WW-1:0]              rd_mask;
	logic [AW-1:0]              size_m1;
	logic [rra_pkg::STAT_W-1:0] fail_code;
	logic                       dst_ok;
	logic                       src_ok;
	logic                       cur_valid;
	logic [AW-1:0]              rb;
	logic [AW-1:0]              rinv;
	logic [AW:0]                rend;
	logic                       hit;
	logic                       last;
	logic [WW-1:0]              setup_base;
	logic [WW-1:0]              setup_mask;
	logic [WW-1:0]              ex_base;
	logic [WW-1:0]              ex_mask;
	logic                       exec_ok;
	logic                       exec_wr;
	logic                       wr_en;
	logic [IW-1:0]              wr_addr;
	logic [WW-1:0]              wr_base;
	logic [WW-1:0]              wr_mask;
	logic                       out_free;

	// window and scan length from configuration
	assign win      = rra_pkg::addr_window(phys_q);
	assign scan_len = (int'(active_q) < NUM_RANGES) ? CW'(active_q) : CW'(NUM_RANGES);

	// single table read port
	always_comb begin
		if (ctl.scan) begin
			rd_addr = scan_idx_q;
		end else if (ctl.write) begin
			rd_addr = free_q;
		end else if (cmd_q == rra_pkg::CMD_COPY) begin
			rd_addr = IW'(src_q);
		end else begin
			rd_addr = IW'(dst_q);
		end
	end
	assign rd_base = rbase_q[rd_addr];
	assign rd_mask = rmask_q[rd_addr];

	// region checks in priority order
	assign size_m1 = size_q - AW'(1);
	always_comb begin
		if (base_q[AW-1:rra_pkg::MIN_BASE_SHIFT] == '0) begin
			fail_code = rra_pkg::STAT_BELOW_1M;
		end else if (base_q[AW-1:rra_pkg::BASE_LIMIT_SHIFT] != '0) begin
			fail_code = rra_pkg::STAT_ABOVE_LIMIT;
		end else if (size_q[AW-1:rra_pkg::MIN_SIZE_SHIFT] == '0) begin
			fail_code = rra_pkg::STAT_UNDER_4K;
		end else if ((size_q & size_m1) != '0) begin
			fail_code = rra_pkg::STAT_NOT_POW2;
		end else if ((base_q & size_m1) != '0) begin
			fail_code = rra_pkg::STAT_MISALIGNED;
		end else if (!ranges_q) begin
			fail_code = rra_pkg::STAT_NO_RANGES;
		end else if (!wc_q) begin
			fail_code = rra_pkg::STAT_NO_WC;
		end else begin
			fail_code = rra_pkg::STAT_OK;
		end
	end

	// overlap test of the scanned entry, end inclusive
	assign cur_valid = rd_mask[rra_pkg::VALID_POS];
	assign rb        = rd_base[AW-1:0] & win[AW-1:0];
	assign rinv      = ~rd_mask[AW-1:0] & win[AW-1:0];
	assign rend      = {1'b0, rb} + {1'b0, rinv};
	assign hit       = cur_valid && ({1'b0, rb} < end_q) && (rend >= {1'b0, base_q});
	assign last      = (CW'(scan_idx_q) + CW'(1)) == scan_len;

	// new words of the chosen entry
	assign setup_base = (rd_base & ~win & ~rra_pkg::TYPE_FIELD)
	                  | ({{(WW-AW){1'b0}}, base_q} & win) | rra_pkg::TYPE_WC;
	assign setup_mask = (rd_mask & ~win)
	                  | ({{(WW-AW){1'b1}}, ~sizem1_q} & win) | rra_pkg::VALID_BIT;

	// enable, disable, copy and read
	assign dst_ok = int'(dst_q) < NUM_RANGES;
	assign src_ok = int'(src_q) < NUM_RANGES;
	always_comb begin
		ex_base = rd_base;
		ex_mask = rd_mask;
		exec_ok = 1'b0;
		exec_wr = 1'b0;
		case (cmd_q)
			rra_pkg::CMD_ENABLE: begin
				ex_mask = rd_mask | rra_pkg::VALID_BIT;
				exec_ok = dst_ok;
				exec_wr = dst_ok;
			end
			rra_pkg::CMD_DISABLE: begin
				ex_mask = rd_mask & ~rra_pkg::VALID_BIT;
				exec_ok = dst_ok;
				exec_wr = dst_ok;
			end
			rra_pkg::CMD_COPY: begin
				exec_ok = dst_ok && src_ok;
				exec_wr = dst_ok && src_ok;
			end
			rra_pkg::CMD_READ: begin
				exec_ok = dst_ok;
			end
			default: begin
				exec_ok = 1'b0;
			end
		endcase
	end

	// table write port
	assign wr_en   = ctl.write || (ctl.exec && exec_wr);
	assign wr_addr = ctl.write ? free_q : IW'(dst_q);
	assign wr_base = ctl.write ? setup_base : ex_base;
	assign wr_mask = ctl.write ? setup_mask : ex_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_RANGES; i++) begin
				rbase_q[i] <= '0;
				rmask_q[i] <= '0;
			end
		end else if (wr_en) begin
			rbase_q[wr_addr] <= wr_base;
			rmask_q[wr_addr] <= wr_mask;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= rra_pkg::ACTIVE_RANGES_RST;
			phys_q   <= rra_pkg::PHYS_BITS_RST;
			ranges_q <= 1'b1;
			wc_q     <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_index)
				rra_pkg::CFG_ACTIVE_RANGES: active_q <= cfg_data[3:0];
				rra_pkg::CFG_PHYS_BITS:     phys_q   <= cfg_data[5:0];
				rra_pkg::CFG_RANGES_SUPP:   ranges_q <= cfg_data[0];
				rra_pkg::CFG_WC_SUPP:       wc_q     <= cfg_data[0];
				default: begin
					active_q <= active_q;
				end
			endcase
		end
	end

	// capture of the input beat
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= in_data.command;
			base_q <= in_data.region_base;
			size_q <= in_data.region_size;
			dst_q  <= in_data.entry_index;
			src_q  <= in_data.source_index;
		end
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q   <= '0;
			free_found_q <= 1'b0;
		end else if (ctl.check) begin
			scan_idx_q   <= '0;
			free_found_q <= 1'b0;
		end else if (ctl.scan) begin
			scan_idx_q <= scan_idx_q + IW'(1);
			if (!cur_valid) begin
				free_found_q <= 1'b1;
			end
		end
	end

	// set-up payload and staged result
	always_ff @(posedge clk) begin
		if (ctl.check) begin
			sizem1_q <= size_m1;
			end_q    <= {1'b0, base_q} + {1'b0, size_q};
			res_q.chosen_index    <= '0;
			res_q.entry_base_word <= '0;
			res_q.entry_mask_word <= '0;
			if (fail_code != rra_pkg::STAT_OK) begin
				res_q.status <= fail_code;
			end else if (scan_len == '0) begin
				res_q.status <= rra_pkg::STAT_FULL;
			end else begin
				res_q.status <= rra_pkg::STAT_OK;
			end
		end
		if (ctl.scan) begin
			if (!cur_valid && !free_found_q) begin
				free_q <= scan_idx_q;
			end
			if (hit) begin
				res_q.status <= rra_pkg::STAT_OVERLAP;
			end else if (last && !(free_found_q || !cur_valid)) begin
				res_q.status <= rra_pkg::STAT_FULL;
			end
		end
		if (ctl.write) begin
			res_q.status          <= rra_pkg::STAT_OK;
			res_q.chosen_index    <= rra_pkg::IDX_W'(free_q);
			res_q.entry_base_word <= setup_base;
			res_q.entry_mask_word <= setup_mask;
		end
		if (ctl.exec) begin
			res_q.status          <= rra_pkg::STAT_OK;
			res_q.chosen_index    <= '0;
			res_q.entry_base_word <= exec_ok ? ex_base : '0;
			res_q.entry_mask_word <= exec_ok ? ex_mask : '0;
		end
	end

	// output register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.push && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// status to controller
	always_comb begin
		sts            = '0;
		sts.is_setup   = (cmd_q == rra_pkg::CMD_SETUP);
		sts.check_fail = (fail_code != rra_pkg::STAT_OK);
		sts.scan_empty = (scan_len == '0);
		sts.scan_hit   = hit;
		sts.scan_last  = last;
		sts.free_avail = free_found_q || !cur_valid;
		sts.out_free   = out_free;
	end

	// scan never reaches past the active entries
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.scan |-> (CW'(scan_idx_q) < scan_len))
		else $error("scan index beyond active entries");

	// set-up only programs an entry that was free
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.write |-> (free_found_q && !rmask_q[free_q][rra_pkg::VALID_POS]))
		else $error("set-up writes a valid entry");

	// programmed entry holds its valid bit afterwards
	a_write_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.write |=> rmask_q[$past(free_q)][rra_pkg::VALID_POS])
		else $error("programmed entry not valid");

	// failed set-up results carry no entry words
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.push && res_q.status != rra_pkg::STAT_OK)
		|-> (res_q.entry_base_word == '0 && res_q.entry_mask_word == '0
			&& res_q.chosen_index == '0))
		else $error("failed result carries entry data");

endmodule

// ===== hw/rtl/range_register_allocator.sv =====
// top level of the range register allocator
//
// Keeps a table of NUM_RANGES variable range entries (64-bit base and mask
// words, mask bit 11 is the valid bit) and runs one command per input beat:
// write-combining set-up, enable, disable, copy or read of an entry.
// Input beats arrive on in_valid/in_stall/in_data, one result beat per
// command leaves on out_valid/out_stall/out_data. Configuration registers
// (active range count, physical address width, support flags) are written
// through cfg_write/cfg_index/cfg_data; the user must write them only while
// no command is in flight, not enforced by the block. Commands run one at
// a time through a controller and a shared datapath. Enable, disable, copy,
// read and set-up that fails a region check go from the check state to the
// push state. Set-up that passes the checks scans one entry per cycle
// through the single table read port over the active range count, capped
// at NUM_RANGES (8 at reset), and stops at the first overlapping entry; if
// none overlaps, the first free entry is programmed in the write state.
// Reset clears every entry to zero (all invalid) and restores the register
// defaults. While out_stall holds a result, the block finishes its current
// command and then waits with in_stall high until the output register frees.
module range_register_allocator #(
	parameter int NUM_RANGES = rra_pkg::NUM_RANGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  rra_pkg::rra_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output rra_pkg::rra_out_t             out_data,
	input  logic                          cfg_write,
	input  logic [rra_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rra_pkg::CFG_W-1:0]     cfg_data
);

	rra_pkg::rra_ctl_t ctl;
	rra_pkg::rra_sts_t sts;

	// command sequencing
	rra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	// entry table and arithmetic
	rra_datapath #(
		.NUM_RANGES (NUM_RANGES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.ctl       (ctl),
		.sts       (sts),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
